// ===== src/bpc_pkg.sv =====
// Package with shared types, constants and helpers of the button press classifier.
`timescale 1ns / 1ps
package bpc_pkg;

	localparam int BUTTON_COUNT = 4;
	localparam int BTN_W = 2;
	localparam int CNT_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam logic [CNT_W-1:0] CNT_SAT = '1;

	localparam logic [CNT_W-1:0] LOCKOUT_RST = 16'd150;
	localparam logic [CNT_W-1:0] LONG_RST = 16'd2000;
	localparam logic [CNT_W-1:0] POWER_RST = 16'd5000;
	localparam logic [CNT_W-1:0] REPEAT_DELAY_RST = 16'd1000;
	localparam logic [CNT_W-1:0] REPEAT_PERIOD_RST = 16'd80;

	typedef enum logic [2:0] {
		KIND_SHORT = 3'd0,
		KIND_LONG = 3'd1,
		KIND_REPEAT = 3'd2,
		KIND_MUTE = 3'd3,
		KIND_POWER = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_LOCKOUT = 3'd0,
		CFG_LONG = 3'd1,
		CFG_POWER = 3'd2,
		CFG_REPEAT_DELAY = 3'd3,
		CFG_REPEAT_PERIOD = 3'd4
	} cfg_idx_t;

	localparam logic [BTN_W-1:0] BTN_THREE = 2'd2;
	localparam logic [BTN_W-1:0] BTN_FOUR = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0] lockout_ticks;
		logic [CNT_W-1:0] long_ticks;
		logic [CNT_W-1:0] power_ticks;
		logic [CNT_W-1:0] repeat_delay_ticks;
		logic [CNT_W-1:0] repeat_period_ticks;
	} cfg_t;

	typedef struct packed {
		logic valid;
		logic [BTN_W-1:0] button;
		kind_t kind;
	} event_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == CNT_SAT) ? CNT_SAT : v + 1'b1;
	endfunction

endpackage

// ===== src/bpc_in_if.sv =====
// Input channel interface carrying one tick of button levels per beat.
`timescale 1ns / 1ps
interface bpc_in_if;
	logic valid;
	logic ready;
	logic [3:0] button_levels;
	logic repeat_allowed;

	modport source (output valid, output button_levels, output repeat_allowed, input ready);
	modport sink (input valid, input button_levels, input repeat_allowed, output ready);
endinterface

// ===== src/bpc_out_if.sv =====
// Output channel interface carrying one classified button event per beat.
`timescale 1ns / 1ps
interface bpc_out_if;
	logic valid;
	logic ready;
	logic [1:0] event_button;
	logic [2:0] event_kind;

	modport source (output valid, output event_button, output event_kind, input ready);
	modport sink (input valid, input event_button, input event_kind, output ready);
endinterface

// ===== src/bpc_cfg_regs.sv =====
// Configuration register file of the button press classifier.
`timescale 1ns / 1ps
module bpc_cfg_regs (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CNT_W-1:0] cfg_wdata,
	output bpc_pkg::cfg_t cfg
);
	import bpc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lockout_ticks <= LOCKOUT_RST;
			cfg_q.long_ticks <= LONG_RST;
			cfg_q.power_ticks <= POWER_RST;
			cfg_q.repeat_delay_ticks <= REPEAT_DELAY_RST;
			cfg_q.repeat_period_ticks <= REPEAT_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_LOCKOUT: cfg_q.lockout_ticks <= cfg_wdata;
				CFG_LONG: cfg_q.long_ticks <= cfg_wdata;
				CFG_POWER: cfg_q.power_ticks <= cfg_wdata;
				CFG_REPEAT_DELAY: cfg_q.repeat_delay_ticks <= cfg_wdata;
				CFG_REPEAT_PERIOD: cfg_q.repeat_period_ticks <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/bpc_core.sv =====
// Tracking state and single-tick classification logic of the button press classifier.
`timescale 1ns / 1ps
module bpc_core (
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  logic [bpc_pkg::BUTTON_COUNT-1:0] levels,
	input  logic rep_ok,
	input  bpc_pkg::cfg_t cfg,
	output bpc_pkg::event_t ev
);
	import bpc_pkg::*;

	logic [BUTTON_COUNT-1:0] prev_q, prev_d;
	logic track_q, track_d;
	logic [BTN_W-1:0] btn_q, btn_d;
	logic [CNT_W-1:0] hold_q, hold_d;
	logic [CNT_W-1:0] since_q, since_d;
	logic fired_q, fired_d;
	logic rmode_q, rmode_d;
	logic [CNT_W-1:0] rcnt_q, rcnt_d;

	logic [BUTTON_COUNT-1:0] rising;
	logic [CNT_W-1:0] since_inc, hold_inc, rcnt_inc;
	logic held;
	logic [BTN_W-1:0] first_btn;

	always_comb begin
		rising = levels & ~prev_q;
		since_inc = sat_inc(since_q);
		hold_inc = sat_inc(hold_q);
		rcnt_inc = sat_inc(rcnt_q);
		held = levels[btn_q];
		if (rising[0]) first_btn = 2'd0;
		else if (rising[1]) first_btn = 2'd1;
		else if (rising[2]) first_btn = 2'd2;
		else first_btn = 2'd3;
	end

	always_comb begin
		prev_d = levels;
		since_d = since_inc;
		track_d = track_q;
		btn_d = btn_q;
		hold_d = hold_q;
		fired_d = fired_q;
		rmode_d = rmode_q;
		rcnt_d = rcnt_q;
		ev.valid = 1'b0;
		ev.button = btn_q;
		ev.kind = KIND_SHORT;
		if (track_q) begin
			if (btn_q == BTN_THREE) begin
				if (held) begin
					hold_d = hold_inc;
					if (!fired_q && hold_inc >= cfg.long_ticks) begin
						fired_d = 1'b1;
						ev.valid = 1'b1;
						ev.kind = KIND_LONG;
					end
				end else begin
					ev.valid = !fired_q;
					track_d = 1'b0;
					since_d = '0;
				end
			end else if (btn_q == BTN_FOUR) begin
				if (held) begin
					hold_d = hold_inc;
					if (!fired_q && hold_inc >= cfg.long_ticks
							&& hold_inc < cfg.power_ticks) begin
						fired_d = 1'b1;
						ev.valid = 1'b1;
						ev.kind = KIND_MUTE;
					end else if (hold_inc >= cfg.power_ticks) begin
						track_d = 1'b0;
						ev.valid = 1'b1;
						ev.kind = KIND_POWER;
					end
				end else begin
					ev.valid = !fired_q;
					track_d = 1'b0;
				end
			end else begin
				if (held) begin
					if (!rmode_q) begin
						hold_d = hold_inc;
						if (hold_inc >= cfg.repeat_delay_ticks) begin
							rmode_d = 1'b1;
							rcnt_d = '0;
							ev.valid = 1'b1;
							ev.kind = KIND_REPEAT;
						end
					end else begin
						rcnt_d = rcnt_inc;
						if (rcnt_inc >= cfg.repeat_period_ticks) begin
							rcnt_d = '0;
							ev.valid = 1'b1;
							ev.kind = KIND_REPEAT;
						end
					end
				end else begin
					track_d = 1'b0;
				end
			end
		end else if (rising != '0 && since_inc > cfg.lockout_ticks) begin
			since_d = '0;
			hold_d = '0;
			fired_d = 1'b0;
			rmode_d = 1'b0;
			rcnt_d = '0;
			btn_d = first_btn;
			ev.button = first_btn;
			if (!first_btn[1]) begin
				ev.valid = 1'b1;
				track_d = rep_ok;
			end else begin
				track_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			track_q <= 1'b0;
			btn_q <= '0;
			hold_q <= '0;
			since_q <= CNT_SAT;
			fired_q <= 1'b0;
			rmode_q <= 1'b0;
			rcnt_q <= '0;
		end else if (step) begin
			prev_q <= prev_d;
			track_q <= track_d;
			btn_q <= btn_d;
			hold_q <= hold_d;
			since_q <= since_d;
			fired_q <= fired_d;
			rmode_q <= rmode_d;
			rcnt_q <= rcnt_d;
		end
	end

endmodule

// ===== src/button_press_classifier.sv =====
// Top level of the button press classifier: input register, core and result register.
//
//  channel   | dir | beat payload
//  ----------+-----+---------------------------------------------
//  in_ch     | in  | button_levels[3:0], repeat_allowed
//  out_ch    | out | event_button[1:0], event_kind[2:0]
//  cfg_*     | in  | cfg_we, cfg_index[2:0], cfg_wdata[15:0]
//
// A beat is taken into the input register, classified by the core, and the
// event, if any, is written to the result register; one beat per cycle is sustained
// while the result register does not stall the core.
// A pending event in the result register only stalls a tick that produces another event.
// Reset clears all tracking state; configuration registers return to their defaults.
`timescale 1ns / 1ps
module button_press_classifier (
	input  logic clk,
	input  logic arst_n,
	bpc_in_if.sink in_ch,
	bpc_out_if.source out_ch,
	input  logic cfg_we,
	input  logic [bpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CNT_W-1:0] cfg_wdata
);
	import bpc_pkg::*;

	cfg_t cfg;
	event_t ev;

	logic vld_s1;
	logic [BUTTON_COUNT-1:0] levels_s1;
	logic rep_s1;
	logic out_vld_q;
	logic [BTN_W-1:0] out_btn_q;
	kind_t out_kind_q;
	logic out_free, adv;

	bpc_cfg_regs u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cfg(cfg)
	);

	bpc_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.step(adv),
		.levels(levels_s1),
		.rep_ok(rep_s1),
		.cfg(cfg),
		.ev(ev)
	);

	assign out_free = !out_vld_q || out_ch.ready;
	assign adv = vld_s1 && (!ev.valid || out_free);
	assign in_ch.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			levels_s1 <= in_ch.button_levels;
			rep_s1 <= in_ch.repeat_allowed;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_free) begin
			out_vld_q <= adv && ev.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && adv && ev.valid) begin
			out_btn_q <= ev.button;
			out_kind_q <= ev.kind;
		end
	end

	assign out_ch.valid = out_vld_q;
	assign out_ch.event_button = out_btn_q;
	assign out_ch.event_kind = out_kind_q;

endmodule
